FILE: rtl/bfbhp_pkg.sv
// package: shared types, marks and field assembly helper for the block file parser
package bfbhp_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS  = 1'b1;

  localparam logic [31:0] FILE_LENGTH_RST = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX_BLOCKS_RST  = 16'd1000;

  localparam logic [7:0] MARK_PTR_NARROW = 8'h5F;  // '_'
  localparam logic [7:0] MARK_PTR_WIDE   = 8'h2D;  // '-'
  localparam logic [7:0] MARK_LITTLE     = 8'h76;  // 'v'
  localparam logic [7:0] MARK_BIG        = 8'h56;  // 'V'
  localparam logic [31:0] CODE_ENDB      = 32'h454E_4442;

  localparam logic [4:0] HDR_PTR_MARK = 5'd7;
  localparam logic [4:0] HDR_END_MARK = 5'd8;
  localparam logic [4:0] HDR_VER_FIRST = 5'd9;
  localparam logic [4:0] HDR_LAST      = 5'd11;

  typedef enum logic [1:0] {
    REC_HEADER  = 2'd0,
    REC_BLOCK   = 2'd1,
    REC_BAD_PTR = 2'd2,
    REC_BAD_END = 2'd3
  } rec_kind_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_BLOCK  = 5'b00100,
    PH_SKIP   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  // add byte b as byte k of a number, in the file's byte order
  function automatic logic [63:0] gather(logic [63:0] v, logic [7:0] b, logic [2:0] k,
                                         logic le);
    logic [63:0] r;
    if (le) begin
      r = v | ({56'd0, b} << {k, 3'b000});
    end else begin
      r = {v[55:0], b};
    end
    return r;
  endfunction

endpackage

FILE: rtl/binary_file_block_header_parser.sv
// top level: byte-serial parser for file header and block headers of a tagged block file
// usage
//   input channel: one file byte per transaction (in_byte_value); in_first_byte marks
//   byte 0 of a new file and restarts the parser at any point. bytes seen before any
//   first byte, after an error record or after the last block record are dropped.
//   output channel: at most one record per input byte: the header record after header
//   byte 11, an error record on a bad pointer-size or endianness mark, and one record
//   per block header on its last header byte. block payloads are skipped by a counter.
//   config port: file_length (index 0) and max_blocks (index 1), written while idle.
// throughput
//   one byte per cycle unless in_stall is raised; a record appears on out_* in the cycle
//   after its last byte. all per-byte work is one pass of field assembly plus one 33-bit
//   end-of-payload add and compare, between the byte and the output register.
// reset
//   synchronous, active low: parser idle until a first byte, config at its defaults
//   (file_length all ones, max_blocks 1000), output register empty.
// stall
//   a single output register parts the channels; while it holds a record and the
//   receiver stalls, in_stall is raised and no byte is taken. otherwise a byte is
//   taken in every cycle, also in the cycle the held record leaves.
module binary_file_block_header_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bfbhp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfbhp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte_value,
  input  logic                              in_first_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_record_kind,
  output logic                              out_pointer_is_wide,
  output logic                              out_lsb_first,
  output logic [23:0]                       out_version_chars,
  output logic [31:0]                       out_block_code,
  output logic [31:0]                       out_payload_size,
  output logic [63:0]                       out_old_pointer,
  output logic [31:0]                       out_struct_index,
  output logic [31:0]                       out_element_count,
  output logic [31:0]                       out_payload_offset,
  output logic                              out_last
);
  import bfbhp_pkg::*;

  // config registers
  logic [31:0] file_length_r;
  logic [15:0] max_blocks_r;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        wide_r, wide_nxt;
  logic        le_r, le_nxt;
  logic [23:0] ver_r, ver_nxt;
  logic [31:0] code_r, code_nxt;
  logic [31:0] size_r, size_nxt;
  logic [63:0] ptr_r, ptr_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [15:0] blocks_r, blocks_nxt;

  // output register
  logic        ovalid_r, ovalid_nxt;
  rec_kind_t   okind_r, okind_nxt;
  logic        owide_r, owide_nxt;
  logic        ole_r, ole_nxt;
  logic [23:0] over_r, over_nxt;
  logic [31:0] ocode_r, ocode_nxt;
  logic [31:0] osize_r, osize_nxt;
  logic [63:0] optr_r, optr_nxt;
  logic [31:0] oidx_r, oidx_nxt;
  logic [31:0] ocount_r, ocount_nxt;
  logic [31:0] ooff_r, ooff_nxt;
  logic        olast_r, olast_nxt;

  logic        in_take;
  logic        out_take;
  logic        rec_emit;
  logic [4:0]  ptr_len;
  logic [63:0] g;
  logic [32:0] end_sum;
  logic        fin;

  assign in_stall = ovalid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;
  assign out_take = ovalid_r & ~out_stall;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    wide_nxt   = wide_r;
    le_nxt     = le_r;
    ver_nxt    = ver_r;
    code_nxt   = code_r;
    size_nxt   = size_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    skip_nxt   = skip_r;
    blocks_nxt = blocks_r;

    rec_emit   = 1'b0;
    okind_nxt  = REC_HEADER;
    owide_nxt  = 1'b0;
    ole_nxt    = 1'b0;
    over_nxt   = '0;
    ocode_nxt  = '0;
    osize_nxt  = '0;
    optr_nxt   = '0;
    oidx_nxt   = '0;
    ocount_nxt = '0;
    ooff_nxt   = '0;
    olast_nxt  = 1'b0;

    g       = '0;
    ptr_len = 5'd4;
    end_sum = '0;
    fin     = 1'b0;

    if (in_take) begin
      // first byte restarts the parse from header byte 0
      if (in_first_byte) begin
        phase_nxt  = PH_HEADER;
        cnt_nxt    = '0;
        wide_nxt   = 1'b0;
        le_nxt     = 1'b0;
        ver_nxt    = '0;
        code_nxt   = '0;
        size_nxt   = '0;
        ptr_nxt    = '0;
        idx_nxt    = '0;
        count_nxt  = '0;
        pos_nxt    = '0;
        skip_nxt   = '0;
        blocks_nxt = '0;
      end

      if (phase_nxt != PH_IDLE && phase_nxt != PH_DONE) begin
        pos_nxt = pos_nxt + 32'd1;
      end

      unique case (phase_nxt)
        PH_HEADER: begin
          if (cnt_nxt == HDR_PTR_MARK) begin
            if (in_byte_value == MARK_PTR_NARROW) begin
              wide_nxt = 1'b0;
            end else if (in_byte_value == MARK_PTR_WIDE) begin
              wide_nxt = 1'b1;
            end else begin
              // bad pointer-size mark ends the parse
              wide_nxt  = 1'b0;
              rec_emit  = 1'b1;
              okind_nxt = REC_BAD_PTR;
              olast_nxt = 1'b1;
              phase_nxt = PH_DONE;
            end
          end else if (cnt_nxt == HDR_END_MARK) begin
            if (in_byte_value == MARK_LITTLE) begin
              le_nxt = 1'b1;
            end else if (in_byte_value == MARK_BIG) begin
              le_nxt = 1'b0;
            end else begin
              le_nxt    = 1'b0;
              rec_emit  = 1'b1;
              okind_nxt = REC_BAD_END;
              owide_nxt = wide_nxt;
              olast_nxt = 1'b1;
              phase_nxt = PH_DONE;
            end
          end else if (cnt_nxt >= HDR_VER_FIRST) begin
            ver_nxt = {ver_nxt[15:0], in_byte_value};
          end

          if (phase_nxt == PH_HEADER) begin
            if (cnt_nxt >= HDR_LAST) begin
              // header complete: report it and start the first block header
              rec_emit   = 1'b1;
              okind_nxt  = REC_HEADER;
              owide_nxt  = wide_nxt;
              ole_nxt    = le_nxt;
              over_nxt   = ver_nxt;
              phase_nxt  = PH_BLOCK;
              cnt_nxt    = '0;
              blocks_nxt = '0;
              code_nxt   = '0;
              size_nxt   = '0;
              ptr_nxt    = '0;
              idx_nxt    = '0;
              count_nxt  = '0;
            end else begin
              cnt_nxt = cnt_nxt + 5'd1;
            end
          end
        end

        PH_BLOCK: begin
          ptr_len = wide_nxt ? 5'd8 : 5'd4;
          // field layout: code 0..3, size 4..7, pointer, index, count
          if (cnt_nxt < 5'd4) begin
            code_nxt = {code_nxt[23:0], in_byte_value};
          end else if (cnt_nxt < 5'd8) begin
            g        = gather({32'd0, size_nxt}, in_byte_value, 3'(cnt_nxt - 5'd4), le_nxt);
            size_nxt = g[31:0];
          end else if (cnt_nxt < 5'd8 + ptr_len) begin
            g       = gather(ptr_nxt, in_byte_value, 3'(cnt_nxt - 5'd8), le_nxt);
            ptr_nxt = wide_nxt ? g : {32'd0, g[31:0]};
          end else if (cnt_nxt < 5'd12 + ptr_len) begin
            g       = gather({32'd0, idx_nxt}, in_byte_value,
                             3'(cnt_nxt - 5'd8 - ptr_len), le_nxt);
            idx_nxt = g[31:0];
          end else begin
            g         = gather({32'd0, count_nxt}, in_byte_value,
                               3'(cnt_nxt - 5'd12 - ptr_len), le_nxt);
            count_nxt = g[31:0];
          end

          if (cnt_nxt < 5'd15 + ptr_len) begin
            cnt_nxt = cnt_nxt + 5'd1;
          end else begin
            // last header byte: position already points at the payload
            end_sum    = {1'b0, pos_nxt} + {1'b0, size_nxt};
            blocks_nxt = blocks_nxt + 16'd1;
            fin        = (code_nxt == CODE_ENDB) ||
                         (end_sum >= {1'b0, file_length_r}) ||
                         (blocks_nxt >= max_blocks_r);
            rec_emit   = 1'b1;
            okind_nxt  = REC_BLOCK;
            owide_nxt  = wide_nxt;
            ole_nxt    = le_nxt;
            over_nxt   = ver_nxt;
            ocode_nxt  = code_nxt;
            osize_nxt  = size_nxt;
            optr_nxt   = ptr_nxt;
            oidx_nxt   = idx_nxt;
            ocount_nxt = count_nxt;
            ooff_nxt   = pos_nxt;
            olast_nxt  = fin;
            cnt_nxt    = '0;
            if (fin) begin
              phase_nxt = PH_DONE;
            end else if (size_nxt == 32'd0) begin
              // empty payload: next byte opens the next block header
              code_nxt  = '0;
              size_nxt  = '0;
              ptr_nxt   = '0;
              idx_nxt   = '0;
              count_nxt = '0;
            end else begin
              skip_nxt  = size_nxt;
              phase_nxt = PH_SKIP;
            end
          end
        end

        PH_SKIP: begin
          skip_nxt = skip_nxt - 32'd1;
          if (skip_nxt == 32'd0) begin
            phase_nxt = PH_BLOCK;
            cnt_nxt   = '0;
            code_nxt  = '0;
            size_nxt  = '0;
            ptr_nxt   = '0;
            idx_nxt   = '0;
            count_nxt = '0;
          end
        end

        PH_IDLE, PH_DONE: begin
          // bytes dropped until a first byte
        end

        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    ovalid_nxt = (ovalid_r & ~out_take) | rec_emit;
  end

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= FILE_LENGTH_RST;
      max_blocks_r  <= MAX_BLOCKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILE_LENGTH: file_length_r <= cfg_data;
        CFG_MAX_BLOCKS:  max_blocks_r  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      wide_r   <= 1'b0;
      le_r     <= 1'b0;
      pos_r    <= '0;
      skip_r   <= '0;
      blocks_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      wide_r   <= wide_nxt;
      le_r     <= le_nxt;
      pos_r    <= pos_nxt;
      skip_r   <= skip_nxt;
      blocks_r <= blocks_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // field assembly registers, cleared by the first byte of each file
  always_ff @(posedge clk) begin
    ver_r   <= ver_nxt;
    code_r  <= code_nxt;
    size_r  <= size_nxt;
    ptr_r   <= ptr_nxt;
    idx_r   <= idx_nxt;
    count_r <= count_nxt;
  end

  // output record, loaded only when a record is produced
  always_ff @(posedge clk) begin
    if (rec_emit) begin
      okind_r  <= okind_nxt;
      owide_r  <= owide_nxt;
      ole_r    <= ole_nxt;
      over_r   <= over_nxt;
      ocode_r  <= ocode_nxt;
      osize_r  <= osize_nxt;
      optr_r   <= optr_nxt;
      oidx_r   <= oidx_nxt;
      ocount_r <= ocount_nxt;
      ooff_r   <= ooff_nxt;
      olast_r  <= olast_nxt;
    end
  end

  assign out_valid           = ovalid_r;
  assign out_record_kind     = okind_r;
  assign out_pointer_is_wide = owide_r;
  assign out_lsb_first       = ole_r;
  assign out_version_chars   = over_r;
  assign out_block_code      = ocode_r;
  assign out_payload_size    = osize_r;
  assign out_old_pointer     = optr_r;
  assign out_struct_index    = oidx_r;
  assign out_element_count   = ocount_r;
  assign out_payload_offset  = ooff_r;
  assign out_last            = olast_r;

endmodule

FILE: tb/sv/binary_file_block_header_parser_test.sv
// self-checking testbench for the byte-serial block file header parser
`timescale 1ns / 1ps

module binary_file_block_header_parser_test;
  import bfbhp_pkg::*;

  // one record as it leaves the parser
  typedef struct packed {
    rec_kind_t   kind;
    logic        wide;
    logic        le;
    logic [23:0] version;
    logic [31:0] code;
    logic [31:0] size;
    logic [63:0] ptr;
    logic [31:0] sidx;
    logic [31:0] count;
    logic [31:0] offset;
    logic        last;
  } parse_rec_t;

  // one input transaction, with an optional hand-typed expectation
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       typed;
    parse_rec_t rec;
  } stim_row_t;

  localparam parse_rec_t NO_REC = '0;
  localparam parse_rec_t BAD_PTR_REC = '{kind: REC_BAD_PTR, last: 1'b1, default: '0};
  localparam parse_rec_t BAD_END_WIDE_REC =
    '{kind: REC_BAD_END, wide: 1'b1, last: 1'b1, default: '0};

  localparam int IDLE_LIMIT  = 3000;  // cycles with no transaction before giving up
  localparam int LONG_HOLD   = 80;    // receiver hold-off, long enough to back up the input
  localparam int PHASE_BYTES = 190;   // random bytes per configuration phase
  localparam int NUM_PHASES  = 8;

  // directed rows: stray byte, bad pointer mark, ignored tail, restart mid-header,
  // bad endianness mark after a wide pointer mark
  localparam stim_row_t DIRECTED_ROWS [22] = '{
    '{8'hA5, 1'b0, 1'b0, NO_REC},            // before any first byte: dropped
    '{8'h00, 1'b1, 1'b0, NO_REC},
    '{8'h42, 1'b0, 1'b0, NO_REC},
    '{8'h4C, 1'b0, 1'b0, NO_REC},
    '{8'h45, 1'b0, 1'b0, NO_REC},
    '{8'h4E, 1'b0, 1'b0, NO_REC},
    '{8'h44, 1'b0, 1'b0, NO_REC},
    '{8'h45, 1'b0, 1'b0, NO_REC},
    '{8'hFF, 1'b0, 1'b1, BAD_PTR_REC},       // header byte 7 is no pointer mark
    '{8'h5F, 1'b0, 1'b0, NO_REC},            // after the error: dropped
    '{8'hFF, 1'b1, 1'b0, NO_REC},
    '{8'h78, 1'b0, 1'b0, NO_REC},
    '{8'h79, 1'b0, 1'b0, NO_REC},
    '{8'h42, 1'b1, 1'b0, NO_REC},            // first byte mid-header: restart
    '{8'h4C, 1'b0, 1'b0, NO_REC},
    '{8'h45, 1'b0, 1'b0, NO_REC},
    '{8'h4E, 1'b0, 1'b0, NO_REC},
    '{8'h44, 1'b0, 1'b0, NO_REC},
    '{8'h45, 1'b0, 1'b0, NO_REC},
    '{8'h52, 1'b0, 1'b0, NO_REC},
    '{MARK_PTR_WIDE, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b1, BAD_END_WIDE_REC}   // header byte 8 is no endianness mark
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FILE_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte_value = 8'h00;
  logic                  in_first_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_record_kind;
  logic                  out_pointer_is_wide;
  logic                  out_lsb_first;
  logic [23:0]           out_version_chars;
  logic [31:0]           out_block_code;
  logic [31:0]           out_payload_size;
  logic [63:0]           out_old_pointer;
  logic [31:0]           out_struct_index;
  logic [31:0]           out_element_count;
  logic [31:0]           out_payload_offset;
  logic                  out_last;

  // travels with each input transaction so the scoreboard sees typed rows
  logic       tag_typed = 1'b0;
  parse_rec_t tag_rec = '0;

  binary_file_block_header_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_value       (in_byte_value),
    .in_first_byte       (in_first_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_record_kind     (out_record_kind),
    .out_pointer_is_wide (out_pointer_is_wide),
    .out_lsb_first       (out_lsb_first),
    .out_version_chars   (out_version_chars),
    .out_block_code      (out_block_code),
    .out_payload_size    (out_payload_size),
    .out_old_pointer     (out_old_pointer),
    .out_struct_index    (out_struct_index),
    .out_element_count   (out_element_count),
    .out_payload_offset  (out_payload_offset),
    .out_last            (out_last)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // parser prediction: its own copy of the configuration and parse state
  // ---------------------------------------------------------------------------
  logic [31:0] file_length_cfg = FILE_LENGTH_RST;
  logic [15:0] max_blocks_cfg  = MAX_BLOCKS_RST;

  phase_t      ps_phase  = PH_IDLE;
  logic [4:0]  ps_cnt    = '0;
  logic        ps_wide   = 1'b0;
  logic        ps_le     = 1'b0;
  logic [23:0] ps_ver    = '0;
  logic [31:0] ps_code   = '0;
  logic [31:0] ps_size   = '0;
  logic [63:0] ps_ptr    = '0;
  logic [31:0] ps_sidx   = '0;
  logic [31:0] ps_count  = '0;
  logic [31:0] ps_pos    = '0;
  logic [31:0] ps_skip   = '0;
  logic [15:0] ps_blocks = '0;

  parse_rec_t pending_records[$];
  int         error_count = 0;

  // place byte b as byte k of a number, in the file's byte order
  function automatic logic [63:0] merge_byte(logic [63:0] v, logic [7:0] b, int k, logic le);
    if (le) begin
      return v | ({56'd0, b} << (8 * k));
    end
    return {v[55:0], b};
  endfunction

  function automatic void clear_block_fields();
    ps_code  = '0;
    ps_size  = '0;
    ps_ptr   = '0;
    ps_sidx  = '0;
    ps_count = '0;
  endfunction

  // advance the predicted parser by one accepted byte
  function automatic void track_byte(input logic [7:0] b, input logic first,
                                     output bit got, output parse_rec_t r);
    int          plen;
    int          c;
    logic [32:0] end_sum;
    bit          fin;
    r   = '0;
    got = 1'b0;
    if (first) begin
      ps_phase  = PH_HEADER;
      ps_cnt    = '0;
      ps_wide   = 1'b0;
      ps_le     = 1'b0;
      ps_ver    = '0;
      clear_block_fields();
      ps_pos    = '0;
      ps_skip   = '0;
      ps_blocks = '0;
    end
    if (ps_phase != PH_HEADER && ps_phase != PH_BLOCK && ps_phase != PH_SKIP) begin
      return;
    end
    ps_pos = ps_pos + 32'd1;
    c = int'(ps_cnt);

    if (ps_phase == PH_HEADER) begin
      if (ps_cnt == HDR_PTR_MARK) begin
        if (b == MARK_PTR_NARROW) begin
          ps_wide = 1'b0;
        end else if (b == MARK_PTR_WIDE) begin
          ps_wide = 1'b1;
        end else begin
          ps_wide  = 1'b0;
          r.kind   = REC_BAD_PTR;
          r.last   = 1'b1;
          got      = 1'b1;
          ps_phase = PH_DONE;
          return;
        end
      end else if (ps_cnt == HDR_END_MARK) begin
        if (b == MARK_LITTLE) begin
          ps_le = 1'b1;
        end else if (b == MARK_BIG) begin
          ps_le = 1'b0;
        end else begin
          ps_le    = 1'b0;
          r.kind   = REC_BAD_END;
          r.wide   = ps_wide;
          r.last   = 1'b1;
          got      = 1'b1;
          ps_phase = PH_DONE;
          return;
        end
      end else if (ps_cnt >= HDR_VER_FIRST) begin
        ps_ver = {ps_ver[15:0], b};
      end
      if (ps_cnt >= HDR_LAST) begin
        r.kind    = REC_HEADER;
        r.wide    = ps_wide;
        r.le      = ps_le;
        r.version = ps_ver;
        got       = 1'b1;
        ps_phase  = PH_BLOCK;
        ps_cnt    = '0;
        ps_blocks = '0;
        clear_block_fields();
        return;
      end
      ps_cnt = ps_cnt + 5'd1;
      return;
    end

    if (ps_phase == PH_SKIP) begin
      ps_skip = ps_skip - 32'd1;
      if (ps_skip == 0) begin
        ps_phase = PH_BLOCK;
        ps_cnt   = '0;
        clear_block_fields();
      end
      return;
    end

    // block header byte: code, size, old pointer, struct index, count
    plen = ps_wide ? 8 : 4;
    if (c < 4) begin
      ps_code = {ps_code[23:0], b};
    end else if (c < 8) begin
      ps_size = 32'(merge_byte({32'd0, ps_size}, b, c - 4, ps_le));
    end else if (c < 8 + plen) begin
      ps_ptr = merge_byte(ps_ptr, b, c - 8, ps_le);
    end else if (c < 12 + plen) begin
      ps_sidx = 32'(merge_byte({32'd0, ps_sidx}, b, c - 8 - plen, ps_le));
    end else begin
      ps_count = 32'(merge_byte({32'd0, ps_count}, b, c - 12 - plen, ps_le));
    end
    if (c < 15 + plen) begin
      ps_cnt = ps_cnt + 5'd1;
      return;
    end

    // ps_pos already points at the first payload byte; the end sum must not wrap
    end_sum   = {1'b0, ps_pos} + {1'b0, ps_size};
    ps_blocks = ps_blocks + 16'd1;
    fin = (ps_code == CODE_ENDB) || (end_sum >= {1'b0, file_length_cfg}) ||
          (ps_blocks >= max_blocks_cfg);

    r.kind    = REC_BLOCK;
    r.wide    = ps_wide;
    r.le      = ps_le;
    r.version = ps_ver;
    r.code    = ps_code;
    r.size    = ps_size;
    r.ptr     = ps_ptr;
    r.sidx    = ps_sidx;
    r.count   = ps_count;
    r.offset  = ps_pos;
    r.last    = fin;
    got       = 1'b1;

    ps_cnt = '0;
    if (fin) begin
      ps_phase = PH_DONE;
    end else if (ps_size == 0) begin
      clear_block_fields();
    end else begin
      ps_skip  = ps_size;
      ps_phase = PH_SKIP;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10) begin
        $display("mismatch %s: expected %0h, got %0h", what, want, got);
      end
    end
  endfunction

  function automatic void check_record(parse_rec_t want);
    check_field("record_kind", 64'(want.kind), 64'(out_record_kind));
    check_field("pointer_is_wide", 64'(want.wide), 64'(out_pointer_is_wide));
    check_field("lsb_first", 64'(want.le), 64'(out_lsb_first));
    check_field("version_chars", 64'(want.version), 64'(out_version_chars));
    check_field("block_code", 64'(want.code), 64'(out_block_code));
    check_field("payload_size", 64'(want.size), 64'(out_payload_size));
    check_field("old_pointer", want.ptr, out_old_pointer);
    check_field("struct_index", 64'(want.sidx), 64'(out_struct_index));
    check_field("element_count", 64'(want.count), 64'(out_element_count));
    check_field("payload_offset", 64'(want.offset), 64'(out_payload_offset));
    check_field("last", 64'(want.last), 64'(out_last));
  endfunction

  // both channels sampled at the edge, before this edge's updates land
  always @(posedge clk) begin : scoreboard
    parse_rec_t rec;
    bit         got;
    if (rst_n) begin
      // results first: a record always stems from an earlier byte
      if (out_valid && !out_stall) begin
        if (pending_records.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: record of kind %0d with none expected", out_record_kind);
          end
        end else begin
          check_record(pending_records.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        track_byte(in_byte_value, in_first_byte, got, rec);
        // typed rows override the prediction for that transaction
        if (tag_typed) begin
          got = 1'b1;
          rec = tag_rec;
        end
        if (got) begin
          pending_records.push_back(rec);
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("binary_file_block_header_parser_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  bit sink_gaps     = 1'b1;
  bit hold_receiver = 1'b0;

  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      if (hold_receiver) begin
        hold_receiver = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // file generation
  // ---------------------------------------------------------------------------
  stim_row_t next_batch[$];

  function automatic void put_byte(logic [7:0] b, logic first);
    stim_row_t row;
    row       = '0;
    row.data  = b;
    row.first = first;
    next_batch.push_back(row);
  endfunction

  // a number of n bytes in the file's byte order
  function automatic void put_number(logic [63:0] v, int n, bit le);
    for (int k = 0; k < n; k++) begin
      put_byte(le ? v[8*k +: 8] : v[8*(n-1-k) +: 8], 1'b0);
    end
  endfunction

  // mostly well-formed files with random content; some noise, bad marks, cut files
  task automatic make_file(input logic [31:0] flen, input logic [15:0] mblk);
    int              style;
    int              start;
    int              cut;
    int              nblk;
    int              count;
    int              plen;
    int              pick;
    bit              wide;
    bit              le;
    bit              fin;
    logic [7:0]      b;
    logic [31:0]     code;
    logic [31:0]     size;
    longint unsigned pos;
    style = $urandom_range(0, 15);
    if (style == 0) begin
      // stray bytes with no first byte
      repeat ($urandom_range(1, 5)) put_byte(8'($urandom), 1'b0);
      return;
    end
    start = next_batch.size();
    put_byte(8'($urandom), 1'b1);
    repeat (6) put_byte(8'($urandom), 1'b0);
    wide = 1'($urandom_range(0, 1));
    le   = 1'($urandom_range(0, 1));
    if (style == 1) begin
      do b = 8'($urandom); while (b == MARK_PTR_NARROW || b == MARK_PTR_WIDE);
      put_byte(b, 1'b0);
      return;
    end
    put_byte(wide ? MARK_PTR_WIDE : MARK_PTR_NARROW, 1'b0);
    if (style == 2) begin
      do b = 8'($urandom); while (b == MARK_LITTLE || b == MARK_BIG);
      put_byte(b, 1'b0);
      return;
    end
    put_byte(le ? MARK_LITTLE : MARK_BIG, 1'b0);
    repeat (3) put_byte(8'($urandom), 1'b0);

    pos   = 12;
    count = 0;
    plen  = wide ? 8 : 4;
    nblk  = $urandom_range(1, 6);
    fin   = 1'b0;
    while (!fin && count < nblk) begin
      code = ($urandom_range(0, 9) == 0) ? CODE_ENDB : 32'($urandom);
      pick = $urandom_range(0, 15);
      if (pick < 4) begin
        size = '0;
      end else if (pick < 13) begin
        size = 32'($urandom_range(1, 6));
      end else if (pick == 13) begin
        size = '1;
      end else if (pick == 14 && flen >= pos + 16 + plen) begin
        // payload ends exactly at the file end
        size = 32'(flen - (pos + 16 + plen));
      end else begin
        size = 32'($urandom_range(1, 3));
      end
      put_number({32'd0, code}, 4, 1'b0);
      put_number({32'd0, size}, 4, le);
      put_number({$urandom, $urandom}, plen, le);
      put_number({32'd0, $urandom}, 4, le);
      put_number({32'd0, $urandom}, 4, le);
      pos += 16 + plen;
      count++;
      fin = (code == CODE_ENDB) || (pos + size >= flen) || (count >= mblk);
      if (!fin) begin
        repeat (size) put_byte(8'($urandom), 1'b0);
        pos += size;
      end
    end

    if (style == 3 && next_batch.size() > start + 1) begin
      // cut short: the next first byte restarts mid-parse
      cut = $urandom_range(start + 1, next_batch.size() - 1);
      while (next_batch.size() > cut) void'(next_batch.pop_back());
    end else if (style == 4) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input stim_row_t row, input bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= row.data;
    in_first_byte <= row.first;
    tag_typed     <= row.typed;
    tag_rec       <= row.rec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // every expected record out, then idle time for bytes that gave none
  task automatic drain_records();
    // first wait until the scoreboard has seen the last accepted byte
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] flen, input logic [15:0] mblk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILE_LENGTH;
    cfg_data  <= flen;
    @(posedge clk);
    cfg_index <= CFG_MAX_BLOCKS;
    cfg_data  <= {16'($urandom), mblk};  // upper bits are don't-care
    @(posedge clk);
    cfg_we <= 1'b0;
    file_length_cfg = flen;
    max_blocks_cfg  = mblk;
  endtask

  initial begin : stimulus
    logic [31:0] flen;
    logic [15:0] mblk;
    bit          send_gaps;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at the reset configuration
    foreach (DIRECTED_ROWS[i]) begin
      offer_byte(DIRECTED_ROWS[i], 1'b1);
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // the sender waits here until every expected record has come
      drain_records();
      send_gaps = 1'b1;
      sink_gaps = 1'b1;
      case (ph)
        0: begin
          flen = '1;
          mblk = 16'hFFFF;
        end
        1: begin
          // every block ends the file
          flen = '0;
          mblk = 16'd1;
        end
        2: begin
          flen = 32'($urandom_range(60, 400));
          mblk = 16'd3;
          send_gaps = 1'b0;
        end
        3: begin
          // zero block limit acts as one
          flen = 32'($urandom_range(100, 2000));
          mblk = 16'd0;
        end
        4: begin
          flen = '1;
          mblk = MAX_BLOCKS_RST;
          send_gaps = 1'b0;
          sink_gaps = 1'b0;
        end
        5: begin
          flen = 32'($urandom_range(20, 300));
          mblk = 16'($urandom_range(2, 6));
        end
        6: begin
          flen = 32'($urandom_range(200, 600));
          mblk = 16'hFFFF;
        end
        default: begin
          // closing stretch, no idling on either side
          flen = '1;
          mblk = MAX_BLOCKS_RST;
          send_gaps = 1'b0;
          sink_gaps = 1'b0;
        end
      endcase
      set_config(flen, mblk);

      next_batch.delete();
      while (next_batch.size() < PHASE_BYTES) make_file(flen, mblk);
      // keep each phase at a fixed byte count; a cut tail acts as a cut file
      while (next_batch.size() > PHASE_BYTES) void'(next_batch.pop_back());

      // receiver backs up the output while the sender keeps offering
      if (ph == 2) begin
        hold_receiver = 1'b1;
      end
      foreach (next_batch[i]) begin
        offer_byte(next_batch[i], send_gaps);
      end
      in_valid <= 1'b0;
    end

    drain_records();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("binary_file_block_header_parser_test: clean");
    end else begin
      $display("binary_file_block_header_parser_test: errors");
    end
    $finish;
  end

endmodule
